### design/shared_prime_factor_detector_unit_defines.svh
// ----------------------------------------------------------------------------
// Shared prime factor detector: assertion macros
// Clocked implication checks with asynchronous active-low reset disable.
// ----------------------------------------------------------------------------
`ifndef SHARED_PRIME_FACTOR_DETECTOR_UNIT_DEFINES_SVH
`define SHARED_PRIME_FACTOR_DETECTOR_UNIT_DEFINES_SVH

// same-cycle implication
`define SPFD_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SPFD_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/spfd_pkg.sv
// ----------------------------------------------------------------------------
// spfd_pkg
// Types, constants and state encodings of the shared prime factor detector.
// ----------------------------------------------------------------------------
`default_nettype none

package spfd_pkg;

	localparam int VALUE_BITS = 30;

	localparam int SIEVE_LIMIT_DEF       = 32768;
	localparam int PRIME_TABLE_DEPTH_DEF = 4096;
	localparam int SEEN_DEPTH_DEF        = 256;

	typedef struct packed {
		logic                  group_start;
		logic [VALUE_BITS-1:0] value;
	} req_t;

	typedef struct packed {
		logic shared_found;
		logic store_overflow;
	} rsp_t;

	typedef enum logic [2:0] {
		SV_CLEAR,
		SV_READ,
		SV_TEST,
		SV_SQ,
		SV_MARK,
		SV_DONE
	} sieve_state_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREAD,
		ST_PWAIT,
		ST_PCMP,
		ST_DIV1,
		ST_CHK,
		ST_CWAIT,
		ST_STRIP,
		ST_DIV2,
		ST_TAIL,
		ST_EMIT
	} fsm_state_t;

endpackage

`default_nettype wire

### design/shared_prime_factor_detector_unit.sv
// Each table prime tried takes a table read, a square, a divider start and a division;
// each further strip division, each seen entry compared and each factor stored adds to
// the time, as does closing out the value; every division goes through the one bit-serial divider.
// One value at a time; ready again as soon as its result is registered.
// Reset: flags and seen count clear at once; the sieve then clears SIEVE_LIMIT bitmap
// entries, one per cycle, and sieves; no value is accepted until it finishes.
// ----------------------------------------------------------------------------
// shared_prime_factor_detector_unit
// Trial-division factoring with a group store of seen primes and sticky flags.
// ----------------------------------------------------------------------------
`default_nettype none

`include "shared_prime_factor_detector_unit_defines.svh"

module shared_prime_factor_detector_unit #(
	parameter int SIEVE_LIMIT       = spfd_pkg::SIEVE_LIMIT_DEF,
	parameter int PRIME_TABLE_DEPTH = spfd_pkg::PRIME_TABLE_DEPTH_DEF,
	parameter int SEEN_DEPTH        = spfd_pkg::SEEN_DEPTH_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_ready,
	input  wire spfd_pkg::req_t req_data,
	output logic               rsp_valid,
	input  wire logic          rsp_ready,
	output spfd_pkg::rsp_t     rsp_data
);
	import spfd_pkg::*;

	localparam int PB  = $clog2(SIEVE_LIMIT);
	localparam int CB  = $clog2(PRIME_TABLE_DEPTH + 1);
	localparam int TAB = $clog2(PRIME_TABLE_DEPTH);
	localparam int SCB = $clog2(SEEN_DEPTH + 1);
	localparam int SAB = $clog2(SEEN_DEPTH);
	localparam int MW  = (2 * PB > VALUE_BITS) ? 2 * PB : VALUE_BITS;

	logic [VALUE_BITS-1:0] seen_mem [SEEN_DEPTH];

	fsm_state_t state_q, state_d;

	logic [VALUE_BITS-1:0] n_q, qsave_q, cand_q, seen_rd_q;
	logic [PB-1:0]         p_q;
	logic [2*PB-1:0]       sq_q;
	logic [CB-1:0]         i_q;
	logic [SCB-1:0]        j_q, seen_cnt_q;
	logic                  found_q, ovf_q, tail_q;
	logic                  rsp_valid_q;
	rsp_t                  rsp_q;

	logic [PB-1:0]         tbl_data;
	logic [CB-1:0]         prime_count;
	logic                  sieve_done;
	logic                  div_start, div_done;
	logic [VALUE_BITS-1:0] div_quo;
	logic [PB-1:0]         div_rem;
	logic                  req_fire, emit_fire, found_eff, sq_over, chk_end, hit;

	spfd_sieve #(
		.SIEVE_LIMIT       (SIEVE_LIMIT),
		.PRIME_TABLE_DEPTH (PRIME_TABLE_DEPTH),
		.PB                (PB),
		.CB                (CB),
		.TAB               (TAB)
	) u_sieve (
		.clk         (clk),
		.arst_n      (arst_n),
		.tbl_addr    (i_q[TAB-1:0]),
		.tbl_data    (tbl_data),
		.prime_count (prime_count),
		.done        (sieve_done)
	);

	spfd_divider #(
		.DIVIDEND_BITS (VALUE_BITS),
		.DIVISOR_BITS  (PB)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (n_q),
		.divisor   (p_q),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	assign req_ready = (state_q == ST_IDLE) && sieve_done;
	assign req_fire  = req_valid && req_ready;
	assign found_eff = found_q && !req_data.group_start;
	assign sq_over   = MW'(sq_q) > MW'(n_q);
	assign chk_end   = (j_q == seen_cnt_q);
	assign hit       = (seen_rd_q == cand_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		emit_fire = 1'b0;
		unique case (state_q)
			ST_IDLE:  if (req_fire) state_d = found_eff ? ST_EMIT : ST_PREAD;
			ST_PREAD: state_d = (i_q == prime_count) ? ST_TAIL : ST_PWAIT;
			ST_PWAIT: state_d = ST_PCMP;
			ST_PCMP: begin
				if (sq_over) begin
					state_d = ST_TAIL;
				end else begin
					div_start = 1'b1;
					state_d   = ST_DIV1;
				end
			end
			ST_DIV1:  if (div_done) state_d = (div_rem == '0) ? ST_CHK : ST_PREAD;
			ST_CHK: begin
				if (chk_end) state_d = tail_q ? ST_EMIT : ST_STRIP;
				else         state_d = ST_CWAIT;
			end
			ST_CWAIT: state_d = hit ? ST_EMIT : ST_CHK;
			ST_STRIP: begin
				div_start = 1'b1;
				state_d   = ST_DIV2;
			end
			ST_DIV2:  if (div_done) state_d = (div_rem == '0) ? ST_STRIP : ST_PREAD;
			ST_TAIL:  state_d = (n_q > VALUE_BITS'(1)) ? ST_CHK : ST_EMIT;
			ST_EMIT: begin
				if (!rsp_valid_q || rsp_ready) begin
					emit_fire = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_cnt_q  <= '0;
			found_q     <= 1'b0;
			ovf_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (req_fire && req_data.group_start) begin
				seen_cnt_q <= '0;
				found_q    <= 1'b0;
				ovf_q      <= 1'b0;
			end
			if (state_q == ST_CHK && chk_end) begin
				if (seen_cnt_q < SCB'(SEEN_DEPTH)) seen_cnt_q <= seen_cnt_q + 1'b1;
				else                               ovf_q      <= 1'b1;
			end
			if (state_q == ST_CWAIT && hit) found_q <= 1'b1;
			if (emit_fire)      rsp_valid_q <= 1'b1;
			else if (rsp_ready) rsp_valid_q <= 1'b0;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				n_q    <= req_data.value;
				i_q    <= '0;
				tail_q <= 1'b0;
			end
			ST_PWAIT: begin
				p_q  <= tbl_data;
				sq_q <= (2 * PB)'(tbl_data) * (2 * PB)'(tbl_data);
			end
			ST_DIV1: begin
				if (div_done) begin
					qsave_q <= div_quo;
					cand_q  <= VALUE_BITS'(p_q);
					j_q     <= '0;
					if (div_rem != '0) i_q <= i_q + 1'b1;
				end
			end
			ST_CHK: begin
				if (chk_end) begin
					if (seen_cnt_q < SCB'(SEEN_DEPTH))
						seen_mem[seen_cnt_q[SAB-1:0]] <= cand_q;
					n_q <= qsave_q;
				end
				seen_rd_q <= seen_mem[j_q[SAB-1:0]];
			end
			ST_CWAIT: j_q <= j_q + 1'b1;
			ST_DIV2: begin
				if (div_done) begin
					if (div_rem == '0) n_q <= div_quo;
					else               i_q <= i_q + 1'b1;
				end
			end
			ST_TAIL: begin
				cand_q <= n_q;
				tail_q <= 1'b1;
				j_q    <= '0;
			end
			default: ;
		endcase
		if (emit_fire) begin
			rsp_q.shared_found   <= found_q;
			rsp_q.store_overflow <= ovf_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	`SPFD_ASSERT_NOW(a_ready_after_sieve, clk, arst_n, req_ready, sieve_done, "ready before sieve done")
	`SPFD_ASSERT_NOW(a_seen_bound, clk, arst_n, 1'b1, seen_cnt_q <= SCB'(SEEN_DEPTH), "seen count overrun")
	`SPFD_ASSERT_NOW(a_ovf_full, clk, arst_n, ovf_q, seen_cnt_q == SCB'(SEEN_DEPTH), "overflow while store not full")
	`SPFD_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, req_fire, !req_ready, "ready right after transfer")

endmodule

`default_nettype wire

### design/spfd_divider.sv
// ----------------------------------------------------------------------------
// spfd_divider
// Restoring divider, one quotient bit per cycle; result valid on done.
// ----------------------------------------------------------------------------
`default_nettype none

module spfd_divider #(
	parameter int DIVIDEND_BITS = 30,
	parameter int DIVISOR_BITS  = 15
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic [DIVIDEND_BITS-1:0] dividend,
	input  wire logic [DIVISOR_BITS-1:0]  divisor,
	output logic                          done,
	output logic [DIVIDEND_BITS-1:0]      quotient,
	output logic [DIVISOR_BITS-1:0]       remainder
);

	localparam int CW = $clog2(DIVIDEND_BITS + 1);

	logic [DIVIDEND_BITS-1:0] quo_q;
	logic [DIVISOR_BITS-1:0]  rem_q;
	logic [DIVISOR_BITS-1:0]  div_q;
	logic [CW-1:0]            cnt_q;
	logic                     done_q;
	logic [DIVISOR_BITS:0]    trial;
	logic [DIVISOR_BITS:0]    diff;
	logic                     ge;

	assign trial = {rem_q, quo_q[DIVIDEND_BITS-1]};
	assign ge    = trial >= {1'b0, div_q};
	assign diff  = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CW'(DIVIDEND_BITS);
			end else if (cnt_q != '0) begin
				cnt_q  <= cnt_q - 1'b1;
				done_q <= (cnt_q == CW'(1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (cnt_q != '0) begin
			quo_q <= {quo_q[DIVIDEND_BITS-2:0], ge};
			rem_q <= ge ? diff[DIVISOR_BITS-1:0] : trial[DIVISOR_BITS-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire

### design/spfd_sieve.sv
// ----------------------------------------------------------------------------
// spfd_sieve
// Clears the composite bitmap, runs the sieve and fills the prime table;
// the table then serves one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module spfd_sieve #(
	parameter int SIEVE_LIMIT       = 32768,
	parameter int PRIME_TABLE_DEPTH = 4096,
	parameter int PB                = $clog2(SIEVE_LIMIT),
	parameter int CB                = $clog2(PRIME_TABLE_DEPTH + 1),
	parameter int TAB               = $clog2(PRIME_TABLE_DEPTH)
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic [TAB-1:0] tbl_addr,
	output logic [PB-1:0]       tbl_data,
	output logic [CB-1:0]       prime_count,
	output logic                done
);
	import spfd_pkg::*;

	localparam int SQW = 2 * PB;
	localparam logic [SQW-1:0] LIM_SQ   = SQW'(SIEVE_LIMIT);
	localparam logic [PB:0]    LIM_K    = (PB + 1)'(SIEVE_LIMIT);
	localparam logic [PB-1:0]  LAST_I   = PB'(SIEVE_LIMIT - 1);

	logic comp_mem [SIEVE_LIMIT];
	logic [PB-1:0] tbl_mem [PRIME_TABLE_DEPTH];

	sieve_state_t state_q, state_d;
	logic [PB-1:0]  i_q;
	logic [PB:0]    k_q;
	logic [SQW-1:0] sq_q;
	logic [CB-1:0]  pcount_q;
	logic           comp_rd_q;
	logic [PB-1:0]  tbl_rd_q;
	logic [PB:0]    k_next;

	assign k_next = k_q + {1'b0, i_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= SV_CLEAR;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			SV_CLEAR: if (i_q == LAST_I) state_d = SV_READ;
			SV_READ:  state_d = SV_TEST;
			SV_TEST: begin
				if (!comp_rd_q)          state_d = SV_SQ;
				else if (i_q == LAST_I)  state_d = SV_DONE;
				else                     state_d = SV_READ;
			end
			SV_SQ: begin
				if (sq_q < LIM_SQ)       state_d = SV_MARK;
				else if (i_q == LAST_I)  state_d = SV_DONE;
				else                     state_d = SV_READ;
			end
			SV_MARK: begin
				if (k_next < LIM_K)      state_d = SV_MARK;
				else if (i_q == LAST_I)  state_d = SV_DONE;
				else                     state_d = SV_READ;
			end
			SV_DONE:  state_d = SV_DONE;
			default:  state_d = SV_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q      <= '0;
			pcount_q <= '0;
		end else begin
			unique case (state_q)
				SV_CLEAR: i_q <= (i_q == LAST_I) ? PB'(2) : i_q + 1'b1;
				SV_TEST: begin
					if (!comp_rd_q && pcount_q < CB'(PRIME_TABLE_DEPTH))
						pcount_q <= pcount_q + 1'b1;
					if (comp_rd_q && i_q != LAST_I) i_q <= i_q + 1'b1;
				end
				SV_SQ:   if (!(sq_q < LIM_SQ) && i_q != LAST_I) i_q <= i_q + 1'b1;
				SV_MARK: if (!(k_next < LIM_K) && i_q != LAST_I) i_q <= i_q + 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == SV_CLEAR) comp_mem[i_q] <= 1'b0;
		if (state_q == SV_MARK)  comp_mem[k_q[PB-1:0]] <= 1'b1;
		comp_rd_q <= comp_mem[i_q];
		if (state_q == SV_TEST) begin
			sq_q <= SQW'(i_q) * SQW'(i_q);
			if (!comp_rd_q && pcount_q < CB'(PRIME_TABLE_DEPTH))
				tbl_mem[pcount_q[TAB-1:0]] <= i_q;
		end
		if (state_q == SV_SQ)   k_q <= sq_q[PB:0];
		if (state_q == SV_MARK) k_q <= k_next;
		tbl_rd_q <= tbl_mem[tbl_addr];
	end

	assign tbl_data    = tbl_rd_q;
	assign prime_count = pcount_q;
	assign done        = (state_q == SV_DONE);

endmodule

`default_nettype wire
